@@ rtl/postfix_expression_evaluator_macros.svh @@
// Assertion macros for the postfix expression evaluator.
// No dependencies; taken in by `include in the modules that assert.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reset disables the check.
`define PFX_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
    else $error("pfx assertion failed");
// Next-cycle implication, reset disables the check.
`define PFX_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
  LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
    else $error("pfx assertion failed");
`else
`define PFX_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS)
`define PFX_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS)
`endif
`endif

@@ rtl/pfx_pkg.sv @@
// Package for the postfix expression evaluator: types, symbol codes, status codes.
// No dependencies.
package pfx_pkg;

  localparam int STACK_ENTRIES_DEF = 64;

  localparam int SYM_W        = 7;
  localparam int VAL_W        = 8;
  localparam int ST_W         = 3;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 7'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 7'h2D;
  localparam logic [SYM_W-1:0] SYM_STAR  = 7'h2A;
  localparam logic [SYM_W-1:0] SYM_SLASH = 7'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 7'h30;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_EMIT
  } state_t;

  // Keep the first error of an expression.
  function automatic status_t note_err(status_t cur, status_t code);
    return (cur == ST_OK) ? code : cur;
  endfunction

endpackage

@@ rtl/pfx_div.sv @@
// Iterative 8-bit signed divider, truncating toward zero, one quotient bit per cycle.
// Depends on pfx_pkg.
module pfx_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pfx_pkg::VAL_W-1:0]   dividend,
  input  logic [pfx_pkg::VAL_W-1:0]   divisor,
  output logic                        done,
  output logic [pfx_pkg::VAL_W-1:0]   quotient
);

  localparam int W   = pfx_pkg::VAL_W;
  localparam int CW  = $clog2(W);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [W-1:0]    rem_r, rem_nxt;
  logic [W-1:0]    quo_r, quo_nxt;
  logic [W-1:0]    dvs_r, dvs_nxt;
  logic            neg_r, neg_nxt;
  logic [W:0]      trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Restoring step: shift one dividend bit into the remainder and try a subtract.
  assign trial = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      // magnitudes; -128 maps to 128, which fits unsigned
      quo_nxt  = dividend[W-1] ? (~dividend + W'(1)) : dividend;
      dvs_nxt  = divisor[W-1]  ? (~divisor  + W'(1)) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? (~quo_r + W'(1)) : quo_r;

endmodule

@@ rtl/postfix_expression_evaluator.sv @@
// Postfix expression evaluator: operand stack in a synchronous RAM, sequencer, ALU.
// Depends on pfx_pkg, pfx_div and postfix_expression_evaluator_macros.svh.
//
// Usage
//   Input stream: one ASCII symbol per request in in_tdata[6:0], in_tlast on the
//   last symbol of an expression. '+', '-', '*', '/' pop two entries and push
//   the 8-bit wrapped result; any other symbol pushes (symbol - '0').
//   Output stream: one request per expression, after its last symbol:
//   out_tdata[7:0] top of stack, out_tdata[10:8] status
//   (0 ok, 1 underflow, 2 overflow, 3 divide by zero, 4 empty).
//   Timing: a push or + - * goes through S_EXEC and back to S_IDLE before the
//   next accept; a divide waits in S_DIV for the bit-serial divider (8 steps).
//   The last symbol goes on to S_EMIT to load the output register. The stack
//   top comes from a register; the entry below it from the RAM read port,
//   issued in the accept cycle.
//   Reset: stack empty, no error, output empty. RAM contents are not
//   cleared; entries at or above the depth are never used.
//   Back-pressure: the result sits in an output register; the next
//   expression's symbols are accepted meanwhile. Only a further result waits
//   for that register to drain.
`include "postfix_expression_evaluator_macros.svh"

module postfix_expression_evaluator #(
  parameter int STACK_ENTRIES = pfx_pkg::STACK_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [6:0] symbol, [7] zero
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pfx_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,
  // out_tdata: [7:0] value, [10:8] status, [15:11] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pfx_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int AW   = $clog2(STACK_ENTRIES);
  localparam int DW   = $clog2(STACK_ENTRIES + 1);
  localparam int VW   = pfx_pkg::VAL_W;
  localparam int SW   = pfx_pkg::SYM_W;
  localparam int PADW = pfx_pkg::OUT_TDATA_W - VW - pfx_pkg::ST_W;

  // stack storage
  logic [VW-1:0] stack_mem [STACK_ENTRIES];

  pfx_pkg::state_t  state_r, state_nxt;
  pfx_pkg::status_t err_r, err_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic [SW-1:0]    sym_r, sym_nxt;
  logic             last_r, last_nxt;
  logic [VW-1:0]    top_r, top_nxt;        // cached copy of stack_mem[depth-1]
  logic [VW-1:0]    rd_data_r;             // entry below the top
  logic             out_valid_r, out_valid_nxt;
  logic [VW-1:0]    out_value_r, out_value_nxt;
  pfx_pkg::status_t out_status_r, out_status_nxt;

  logic             accept;
  logic             emit_go;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [VW-1:0]    mem_wd;
  logic [AW-1:0]    rd_addr;
  logic [DW-1:0]    depth_m2;
  logic             sym_is_op;
  logic [VW-1:0]    push_val;
  logic [2*VW-1:0]  product;
  logic [VW-1:0]    alu_res;
  logic             div_start;
  logic             div_done;
  logic [VW-1:0]    div_quo;
  pfx_pkg::state_t  finish_state;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == pfx_pkg::S_IDLE);
  assign emit_go   = (state_r == pfx_pkg::S_EMIT) && (!out_valid_r || out_tready);

  assign depth_m2  = depth_r - DW'(2);
  assign rd_addr   = depth_m2[AW-1:0];

  assign sym_is_op = (sym_r == pfx_pkg::SYM_PLUS)  || (sym_r == pfx_pkg::SYM_MINUS) ||
                     (sym_r == pfx_pkg::SYM_STAR)  || (sym_r == pfx_pkg::SYM_SLASH);
  assign push_val  = {1'b0, sym_r} - {1'b0, pfx_pkg::SYM_ZERO};
  assign product   = rd_data_r * top_r;    // low byte equals the signed product's

  // a = rd_data_r (lower), b = top_r (top); wrapping 8-bit results
  always_comb begin
    unique case (sym_r)
      pfx_pkg::SYM_PLUS:  alu_res = rd_data_r + top_r;
      pfx_pkg::SYM_MINUS: alu_res = rd_data_r - top_r;
      default:            alu_res = product[VW-1:0];
    endcase
  end

  assign finish_state = last_r ? pfx_pkg::S_EMIT : pfx_pkg::S_IDLE;

  // RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfx_pkg::S_IDLE;
      err_r       <= pfx_pkg::ST_OK;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    top_r        <= top_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    err_nxt        = err_r;
    depth_nxt      = depth_r;
    sym_nxt        = sym_r;
    last_nxt       = last_r;
    top_nxt        = top_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_wa         = rd_addr;
    mem_wd         = alu_res;
    div_start      = 1'b0;

    unique case (state_r)
      pfx_pkg::S_IDLE: begin
        if (accept) begin
          sym_nxt   = in_tdata[SW-1:0];
          last_nxt  = in_tlast;
          state_nxt = pfx_pkg::S_EXEC;
        end
      end

      pfx_pkg::S_EXEC: begin
        state_nxt = finish_state;
        if (!sym_is_op) begin
          if (depth_r >= DW'(STACK_ENTRIES)) begin
            err_nxt = pfx_pkg::note_err(err_r, pfx_pkg::ST_OVERFLOW);
          end else begin
            mem_we    = 1'b1;
            mem_wa    = depth_r[AW-1:0];
            mem_wd    = push_val;
            top_nxt   = push_val;
            depth_nxt = depth_r + DW'(1);
          end
        end else if (depth_r < DW'(2)) begin
          err_nxt = pfx_pkg::note_err(err_r, pfx_pkg::ST_UNDERFLOW);
        end else if (sym_r == pfx_pkg::SYM_SLASH) begin
          if (top_r == '0) begin
            // pop both, push zero
            err_nxt   = pfx_pkg::note_err(err_r, pfx_pkg::ST_DIVZERO);
            mem_we    = 1'b1;
            mem_wd    = '0;
            top_nxt   = '0;
            depth_nxt = depth_r - DW'(1);
          end else begin
            div_start = 1'b1;
            state_nxt = pfx_pkg::S_DIV;
          end
        end else begin
          mem_we    = 1'b1;
          top_nxt   = alu_res;
          depth_nxt = depth_r - DW'(1);
        end
      end

      pfx_pkg::S_DIV: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wd    = div_quo;
          top_nxt   = div_quo;
          depth_nxt = depth_r - DW'(1);
          state_nxt = finish_state;
        end
      end

      pfx_pkg::S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          if (depth_r == '0) begin
            out_value_nxt  = '0;
            out_status_nxt = pfx_pkg::note_err(err_r, pfx_pkg::ST_EMPTY);
          end else begin
            out_value_nxt  = top_r;
            out_status_nxt = err_r;
          end
          depth_nxt = '0;
          err_nxt   = pfx_pkg::ST_OK;
          state_nxt = pfx_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pfx_pkg::S_IDLE;
      end
    endcase
  end

  pfx_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (top_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PADW{1'b0}}, out_status_r, out_value_r};

  `PFX_ASSERT_SAME(a_depth_bound, clk, rst_n, 1'b1, depth_r <= DW'(STACK_ENTRIES))
  `PFX_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_r == pfx_pkg::S_EXEC)
  `PFX_ASSERT_SAME(a_div_in_div, clk, rst_n, div_done, state_r == pfx_pkg::S_DIV)
  `PFX_ASSERT_NEXT(a_emit_clears, clk, rst_n, emit_go, (depth_r == '0) && (err_r == pfx_pkg::ST_OK) && out_valid_r)

endmodule

@@ tb/tb_postfix_expression_evaluator.sv @@
// Self-checking testbench for postfix_expression_evaluator: drives ASCII symbol
// streams, predicts each expression's result in a scoreboard class and checks it.
// Depends on pfx_pkg and the postfix_expression_evaluator RTL.
`timescale 1ns / 100ps

module tb_postfix_expression_evaluator;

  localparam int STACK_DEPTH   = pfx_pkg::STACK_ENTRIES_DEF;
  localparam int TOTAL_SYMBOLS = 1775;   // directed part plus about 1750 random symbols
  localparam int IDLE_LIMIT    = 2000;   // cycles without any accepted request
  localparam int DRAIN_CYCLES  = 40;     // quiet time after the last expected result

  // not an operator here, pushes 46
  localparam logic [pfx_pkg::SYM_W-1:0] SYM_CARET = 7'h5E;

  // One expected answer per expression.
  typedef struct packed {
    logic [pfx_pkg::VAL_W-1:0] value;
    pfx_pkg::status_t          status;
  } answer_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: carries its own operand stack and sticky error, turns every
  // accepted symbol into stack updates and queues an answer on the last one.
  // ---------------------------------------------------------------------------
  class rpn_scoreboard;
    logic [pfx_pkg::VAL_W-1:0] operands [STACK_DEPTH];
    int unsigned               live_depth;
    pfx_pkg::status_t          sticky_err;
    answer_t                   answers_q [$];
    int unsigned               fail_count;

    function new();
      live_depth = 0;
      sticky_err = pfx_pkg::ST_OK;
      fail_count = 0;
    endfunction

    // Only the first error of an expression survives.
    function void flag_error(pfx_pkg::status_t code);
      if (sticky_err == pfx_pkg::ST_OK) sticky_err = code;
    endfunction

    function void push_operand(logic [pfx_pkg::VAL_W-1:0] v);
      if (live_depth >= STACK_DEPTH) begin
        flag_error(pfx_pkg::ST_OVERFLOW);   // push onto a full stack is dropped
        return;
      end
      operands[live_depth] = v;
      live_depth++;
    endfunction

    function void note_request(logic [pfx_pkg::SYM_W-1:0] sym, logic last);
      int      lhs;
      int      rhs;
      int      r;
      answer_t ans;
      if (sym inside {pfx_pkg::SYM_PLUS, pfx_pkg::SYM_MINUS,
                      pfx_pkg::SYM_STAR, pfx_pkg::SYM_SLASH}) begin
        if (live_depth < 2) begin
          flag_error(pfx_pkg::ST_UNDERFLOW);  // stack left untouched
        end else begin
          rhs = $signed(operands[live_depth-1]);
          lhs = $signed(operands[live_depth-2]);
          live_depth -= 2;
          case (sym)
            pfx_pkg::SYM_PLUS:  r = lhs + rhs;
            pfx_pkg::SYM_MINUS: r = lhs - rhs;
            pfx_pkg::SYM_STAR:  r = lhs * rhs;
            default: begin
              // truncating divide; -128 / -1 simply wraps back to -128
              if (rhs == 0) begin
                flag_error(pfx_pkg::ST_DIVZERO);
                r = 0;
              end else begin
                r = lhs / rhs;
              end
            end
          endcase
          push_operand(r[pfx_pkg::VAL_W-1:0]);
        end
      end else begin
        push_operand(8'({1'b0, sym}) - 8'({1'b0, pfx_pkg::SYM_ZERO}));
      end

      if (last) begin
        ans.status = sticky_err;
        if (live_depth == 0) begin
          ans.value = '0;
          if (sticky_err == pfx_pkg::ST_OK) ans.status = pfx_pkg::ST_EMPTY;
        end else begin
          ans.value = operands[live_depth-1];
        end
        answers_q.push_back(ans);
        live_depth = 0;
        sticky_err = pfx_pkg::ST_OK;
      end
    endfunction

    function void check_result(logic [pfx_pkg::OUT_TDATA_W-1:0] tdata);
      answer_t ans;
      if (answers_q.size() == 0) begin
        $error("unexpected result: value %0d, status %0d", $signed(tdata[7:0]), tdata[10:8]);
        fail_count++;
        return;
      end
      ans = answers_q.pop_front();
      if (tdata[7:0] !== ans.value) begin
        $error("value: expected %0d, got %0d", $signed(ans.value), $signed(tdata[7:0]));
        fail_count++;
      end
      if (tdata[10:8] !== ans.status) begin
        $error("status: expected %0d, got %0d", ans.status, tdata[10:8]);
        fail_count++;
      end
    endfunction

    function int pending();
      return answers_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [pfx_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;   // [6:0] symbol, [7] zero
  logic                            in_tlast   = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // [7:0] value, [10:8] status, [15:11] zero
  logic [pfx_pkg::OUT_TDATA_W-1:0] out_tdata;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  postfix_expression_evaluator #(
    .STACK_ENTRIES(STACK_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  rpn_scoreboard sb = new();

  // ---------------------------------------------------------------------------
  // Monitor: sampled right after the edge, so these are the values the DUT saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_request(in_tdata[pfx_pkg::SYM_W-1:0], in_tlast);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Watchdog: any accepted request on either side restarts the count.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb_postfix_expression_evaluator: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: back-pressure switches between phases of always-ready, coin-flip
  // and mostly-stalled, so stalls land on every stage of the block's work.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(50, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  int                        burst_left   = 0;
  int                        symbols_sent = 0;
  logic [pfx_pkg::SYM_W-1:0] expr_q [$];

  // One symbol request; bursts of random length separated by random gaps.
  // tvalid only drops when a gap actually follows, never within one step.
  task automatic send_symbol(input logic [pfx_pkg::SYM_W-1:0] sym, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, sym};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    symbols_sent++;
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) send_symbol(expr_q[i], i == expr_q.size() - 1);
  endtask

  // Symbol that pushes n (n from -48 to 79).
  function automatic logic [pfx_pkg::SYM_W-1:0] digit(int n);
    return 7'(pfx_pkg::SYM_ZERO + n);
  endfunction

  function automatic logic [pfx_pkg::SYM_W-1:0] random_operator();
    case ($urandom_range(0, 3))
      0:       return pfx_pkg::SYM_PLUS;
      1:       return pfx_pkg::SYM_MINUS;
      2:       return pfx_pkg::SYM_STAR;
      default: return pfx_pkg::SYM_SLASH;
    endcase
  endfunction

  // Mostly decimal digits (plenty of zeros for divide-by-zero), sometimes any
  // non-operator code so pushed values span the whole range from -48 to 79.
  function automatic logic [pfx_pkg::SYM_W-1:0] random_operand();
    logic [pfx_pkg::SYM_W-1:0] s;
    if ($urandom_range(0, 3) != 0) return digit($urandom_range(0, 9));
    do s = 7'($urandom_range(0, 127));
    while (s inside {pfx_pkg::SYM_PLUS, pfx_pkg::SYM_MINUS,
                     pfx_pkg::SYM_STAR, pfx_pkg::SYM_SLASH});
    return s;
  endfunction

  // Well-formed expression: ends with exactly one entry on the stack.
  task automatic build_wellformed(input int n_operands);
    int live;
    int pushed;
    live   = 0;
    pushed = 0;
    expr_q.delete();
    while (pushed < n_operands || live > 1) begin
      if (pushed < n_operands && (live < 2 || $urandom_range(0, 1) == 1)) begin
        expr_q.push_back(random_operand());
        pushed++;
        live++;
      end else begin
        expr_q.push_back(random_operator());
        live--;
      end
    end
  endtask

  // Well-formed, then one symbol dropped or a stray operator inserted.
  task automatic build_broken();
    build_wellformed($urandom_range(1, 6));
    if ($urandom_range(0, 1) == 1 && expr_q.size() > 1)
      expr_q.delete($urandom_range(0, expr_q.size() - 1));
    else
      expr_q.insert($urandom_range(0, expr_q.size()), random_operator());
  endtask

  // Runs near or past the stack's capacity, then folds up to five entries.
  task automatic build_deep();
    int n_ops;
    expr_q.delete();
    repeat ($urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 8)) expr_q.push_back(random_operand());
    n_ops = $urandom_range(0, 5);
    repeat (n_ops) expr_q.push_back(random_operator());
  endtask

  // Any code, operators weighted up; tlast may also fall mid-stream.
  task automatic send_noise();
    int                        n;
    logic [pfx_pkg::SYM_W-1:0] s;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(0, 3) == 0) ? random_operator() : 7'($urandom_range(0, 127));
      send_symbol(s, (i == n - 1) || ($urandom_range(0, 3) == 0));
    end
  endtask

  int pick;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed expressions.
    expr_q = '{digit(1), digit(2), pfx_pkg::SYM_PLUS};
    send_expr();
    // -4 * 7 / 3: subtract order, multiply, divide truncating toward zero
    expr_q = '{digit(5), digit(9), pfx_pkg::SYM_MINUS, digit(7), pfx_pkg::SYM_STAR,
               digit(3), pfx_pkg::SYM_SLASH};
    send_expr();
    // 64 * 2 wraps to -128, then -128 / -1 wraps back to -128 with no error
    expr_q = '{digit(64), digit(2), pfx_pkg::SYM_STAR, digit(0), digit(1),
               pfx_pkg::SYM_MINUS, pfx_pkg::SYM_SLASH};
    send_expr();
    // lone operator: underflow on an empty stack, value reads 0
    expr_q = '{pfx_pkg::SYM_PLUS};
    send_expr();
    // divide by zero pushes 0, the later underflow must not replace it
    expr_q = '{digit(5), digit(0), pfx_pkg::SYM_SLASH, pfx_pkg::SYM_PLUS};
    send_expr();
    // caret is just another operand
    expr_q = '{SYM_CARET};
    send_expr();
    // lowest and highest symbol codes
    expr_q = '{digit(-48), digit(79), pfx_pkg::SYM_PLUS};
    send_expr();

    // Random part: mostly well-formed, plus broken, overflowing and noise runs.
    while (symbols_sent < TOTAL_SYMBOLS) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        build_wellformed($urandom_range(1, 8));
        send_expr();
      end else if (pick < 84) begin
        build_broken();
        send_expr();
      end else if (pick < 86) begin
        build_deep();
        send_expr();
      end else begin
        send_noise();
      end
    end
    in_tvalid <= 1'b0;

    // let the monitor log the final request before looking at the queue
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("tb_postfix_expression_evaluator: PASS");
    end else begin
      $display("tb_postfix_expression_evaluator: FAIL");
    end
    $finish;
  end

endmodule
